>>> src/pbcas_pkg.sv
// ----------------------------------------------------------------------------
// pbcas_pkg
// Shared types, constants and lookup functions for the bridge configuration
// access shim.
// ----------------------------------------------------------------------------
package pbcas_pkg;

   // Access kinds.
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Access sizes that get a mask or a merge; anything else is a full word.
   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;

   // Status codes.
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] REG_EA_BASE_LOW  = 2'd0;
   localparam logic [1:0] REG_EA_SIZE      = 2'd1;
   localparam logic [1:0] REG_EA_BASE_HIGH = 2'd2;

   localparam int          CSR_ADDR_WIDTH = 4;
   localparam logic [11:0] LIMIT_OFFSET   = 12'd2048;

   // Aligned configuration offsets with special handling.
   localparam logic [11:0] OFS_ID         = 12'h000;
   localparam logic [11:0] OFS_CMD_STATUS = 12'h004;
   localparam logic [11:0] OFS_CLASS      = 12'h008;
   localparam logic [11:0] OFS_HEADER     = 12'h00c;
   localparam logic [11:0] OFS_BUS_NUM    = 12'h018;
   localparam logic [11:0] OFS_IO_STATUS  = 12'h01c;
   localparam logic [11:0] OFS_PREF_MEM   = 12'h024;
   localparam logic [11:0] OFS_CAP_PTR    = 12'h040;
   localparam logic [11:0] OFS_CAP_44     = 12'h044;
   localparam logic [11:0] OFS_EA_LOW     = 12'h05c;
   localparam logic [11:0] OFS_EA_SIZE    = 12'h060;
   localparam logic [11:0] OFS_EA_HIGH    = 12'h064;
   localparam logic [11:0] OFS_INT_VEC    = 12'h070;
   localparam logic [11:0] OFS_STS_78     = 12'h078;
   localparam logic [11:0] OFS_STS_80     = 12'h080;
   localparam logic [11:0] OFS_STS_88     = 12'h088;
   localparam logic [11:0] OFS_STS_90     = 12'h090;
   localparam logic [11:0] OFS_STS_A0     = 12'h0a0;
   localparam logic [11:0] OFS_ERR_104    = 12'h104;
   localparam logic [11:0] OFS_ERR_110    = 12'h110;
   localparam logic [11:0] OFS_ERR_130    = 12'h130;
   localparam logic [11:0] OFS_ERR_180    = 12'h180;

   // Fixed read values.
   localparam logic [31:0] ID_WORD         = 32'hA02D177D;
   localparam logic [31:0] CMD_STATUS_WORD = 32'h00100006;
   localparam logic [31:0] CLASS_WORD      = 32'h06040100;
   localparam logic [31:0] HEADER_WORD     = 32'h00010000;
   localparam logic [31:0] BUS_NUM_WORD    = 32'h00010100;
   localparam logic [31:0] CAP_KEEP_MASK   = 32'hffff00ff;
   localparam logic [31:0] CAP_PTR_BITS    = 32'h00005000;

   typedef struct packed {
      logic        op;
      logic [7:0]  function_number;
      logic [11:0] offset;
      logic [2:0]  access_size;
      logic [31:0] write_data;
      logic [31:0] current_word;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] read_data;
      logic        write_enable;
      logic [10:0] write_address;
      logic [31:0] write_word;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base_low;
      logic [31:0] size;
      logic [31:0] base_high;
   } ea_regs_type;

   // Write-1-to-clear bits of the word at an aligned offset.
   function automatic logic [31:0] clear_bits(input logic [11:0] aligned);
      logic [31:0] bits;
      bits = 32'h0;
      case (aligned)
         OFS_CMD_STATUS, OFS_IO_STATUS: bits = 32'hff000000;
         OFS_CAP_44:                    bits = 32'hfffffe00;
         OFS_STS_78, OFS_STS_80, OFS_STS_88, OFS_STS_90, OFS_STS_A0:
            bits = 32'hffff0000;
         OFS_ERR_104, OFS_ERR_110, OFS_ERR_130, OFS_ERR_180:
            bits = 32'hffffffff;
         default: bits = 32'h0;
      endcase
      return bits;
   endfunction

   // Bits forced to one on every write of the word at an aligned offset.
   function automatic logic [31:0] one_bits(input logic [11:0] aligned);
      logic [31:0] bits;
      bits = 32'h0;
      case (aligned)
         OFS_IO_STATUS: bits = 32'h00000101;
         OFS_PREF_MEM:  bits = 32'h00010001;
         default:       bits = 32'h0;
      endcase
      return bits;
   endfunction

endpackage

>>> src/pbcas_if.sv
// ----------------------------------------------------------------------------
// pbcas request and response channels
// Valid/ready channels carrying one access request and one access result.
// ----------------------------------------------------------------------------
interface pbcas_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [7:0]  function_number;
   logic [11:0] offset;
   logic [2:0]  access_size;
   logic [31:0] write_data;
   logic [31:0] current_word;

   modport source (
      output valid, op, function_number, offset, access_size, write_data,
             current_word,
      input  ready
   );
   modport sink (
      input  valid, op, function_number, offset, access_size, write_data,
             current_word,
      output ready
   );
endinterface

interface pbcas_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic [31:0] read_data;
   logic        write_enable;
   logic [10:0] write_address;
   logic [31:0] write_word;

   modport source (
      output valid, status, read_data, write_enable, write_address, write_word,
      input  ready
   );
   modport sink (
      input  valid, status, read_data, write_enable, write_address, write_word,
      output ready
   );
endinterface

>>> src/pbcas_csr.sv
// ----------------------------------------------------------------------------
// pbcas_csr
// APB register file holding the three enhanced-allocation words.
// ----------------------------------------------------------------------------
module pbcas_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pbcas_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready,
   output pbcas_pkg::ea_regs_type              ea_regs
);

   pbcas_pkg::ea_regs_type regs_ff, regs_in;
   logic                   wr_en;
   logic [1:0]             reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (reg_index)
            pbcas_pkg::REG_EA_BASE_LOW:  regs_in.base_low  = pwdata;
            pbcas_pkg::REG_EA_SIZE:      regs_in.size      = pwdata;
            pbcas_pkg::REG_EA_BASE_HIGH: regs_in.base_high = pwdata;
            default:                     regs_in = regs_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         pbcas_pkg::REG_EA_BASE_LOW:  prdata = regs_ff.base_low;
         pbcas_pkg::REG_EA_SIZE:      prdata = regs_ff.size;
         pbcas_pkg::REG_EA_BASE_HIGH: prdata = regs_ff.base_high;
         default:                     prdata = 32'h0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign ea_regs = regs_ff;

endmodule

>>> src/pbcas_fixup.sv
// ----------------------------------------------------------------------------
// pbcas_fixup
// Decode, read patching, shift and mask, and write merge of one access.
// ----------------------------------------------------------------------------
module pbcas_fixup (
   input  pbcas_pkg::req_type     req,
   input  pbcas_pkg::ea_regs_type ea_regs,
   output pbcas_pkg::rsp_type     rsp
);

   logic        not_found;
   logic [11:0] aligned;
   logic [4:0]  shamt;
   logic [31:0] patched;
   logic [31:0] shifted;
   logic [31:0] lanes;
   logic [31:0] keep;
   logic [31:0] merged;
   logic [31:0] wr_word;
   logic        narrow;

   assign not_found = (req.function_number != 8'd0) ||
                      (req.offset >= pbcas_pkg::LIMIT_OFFSET);
   assign aligned   = {req.offset[11:2], 2'b00};
   assign shamt     = {req.offset[1:0], 3'b000};

   // Read side: patch the raw word for the emulated header fields.
   always_comb begin
      patched = req.current_word;
      case (aligned)
         pbcas_pkg::OFS_ID:         patched = pbcas_pkg::ID_WORD;
         pbcas_pkg::OFS_CMD_STATUS: patched = pbcas_pkg::CMD_STATUS_WORD;
         pbcas_pkg::OFS_CLASS:      patched = pbcas_pkg::CLASS_WORD;
         pbcas_pkg::OFS_HEADER:     patched = pbcas_pkg::HEADER_WORD;
         pbcas_pkg::OFS_BUS_NUM:    patched = pbcas_pkg::BUS_NUM_WORD;
         pbcas_pkg::OFS_CAP_PTR:
            patched = (req.current_word & pbcas_pkg::CAP_KEEP_MASK) |
                      pbcas_pkg::CAP_PTR_BITS;
         pbcas_pkg::OFS_EA_LOW:     patched = ea_regs.base_low;
         pbcas_pkg::OFS_EA_SIZE:    patched = ea_regs.size;
         pbcas_pkg::OFS_EA_HIGH:    patched = ea_regs.base_high;
         pbcas_pkg::OFS_INT_VEC: begin
            // An unassigned interrupt vector reads back as vector one.
            if (req.current_word[29:25] == 5'd0) begin
               patched = req.current_word | 32'h02000000;
            end
         end
         default: patched = req.current_word;
      endcase
   end

   always_comb begin
      shifted = patched >> shamt;
      case (req.access_size)
         pbcas_pkg::SIZE_BYTE: shifted = shifted & 32'h000000ff;
         pbcas_pkg::SIZE_HALF: shifted = shifted & 32'h0000ffff;
         default:              shifted = shifted;
      endcase
   end

   // Write side: merge narrow writes and apply the clear and set rules.
   always_comb begin
      narrow  = (req.access_size == pbcas_pkg::SIZE_BYTE) ||
                (req.access_size == pbcas_pkg::SIZE_HALF);
      lanes   = (req.access_size == pbcas_pkg::SIZE_BYTE) ? 32'h000000ff : 32'h0000ffff;
      keep    = ~(lanes << shamt);
      merged  = ((req.write_data & lanes) << shamt) | (req.current_word & keep);
      wr_word = narrow ? merged : req.write_data;
      // Write-1-to-clear bits in untouched bytes must not echo back as ones.
      if (narrow && (keep != 32'h0)) begin
         wr_word = wr_word & ~(keep & pbcas_pkg::clear_bits(aligned));
      end
      wr_word = wr_word | pbcas_pkg::one_bits(aligned);
   end

   always_comb begin
      rsp = '0;
      if (not_found) begin
         rsp.status = pbcas_pkg::STATUS_NOT_FOUND;
         if (req.op == pbcas_pkg::OP_READ) begin
            rsp.read_data = 32'hffffffff;
         end
      end else if (req.op == pbcas_pkg::OP_READ) begin
         rsp.status    = pbcas_pkg::STATUS_OK;
         rsp.read_data = shifted;
      end else begin
         rsp.status        = pbcas_pkg::STATUS_OK;
         rsp.write_enable  = 1'b1;
         rsp.write_address = aligned[10:0];
         rsp.write_word    = wr_word;
      end
   end

endmodule

>>> src/pcie_bridge_config_access_shim.sv
// ----------------------------------------------------------------------------
// pcie_bridge_config_access_shim
// Bridge configuration access fixup with an input register and a result
// register around one pass of decode, patch and merge logic.
// ----------------------------------------------------------------------------
// The block takes one configuration request per clock unless the result side
// stalls, and returns exactly one result per request, in order. A request is
// captured in the input register, processed in one pass of combinational
// logic and held in the result register, from which it is shown on the result
// channel. The sustained rate is one request per cycle while the result side
// takes one per cycle. An empty input register takes a new request while a
// finished result waits. The user must write the three enhanced-allocation
// words through the APB port only while no request is in flight; the block
// itself does not enforce this. There is no clearing pass after reset.
module pcie_bridge_config_access_shim (
   input  logic                                clock,
   input  logic                                reset,
   pbcas_req_if.sink                           req_bus,
   pbcas_rsp_if.source                         rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pbcas_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   pbcas_pkg::ea_regs_type ea_regs;
   pbcas_pkg::req_type     s1_req_ff, s1_req_in;
   logic                   s1_valid_ff, s1_valid_in;
   pbcas_pkg::rsp_type     out_rsp_ff, out_rsp_in;
   logic                   out_valid_ff, out_valid_in;
   pbcas_pkg::rsp_type     fix_rsp;
   logic                   out_free;
   logic                   s1_free;
   logic                   req_take;

   pbcas_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .ea_regs (ea_regs)
   );

   pbcas_fixup u_fixup (
      .req     (s1_req_ff),
      .ea_regs (ea_regs),
      .rsp     (fix_rsp)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_free       = !s1_valid_ff || out_free;
   assign req_bus.ready = s1_free;
   assign req_take      = req_bus.valid && s1_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (s1_free) begin
         s1_valid_in                 = req_bus.valid;
         s1_req_in.op                = req_bus.op;
         s1_req_in.function_number   = req_bus.function_number;
         s1_req_in.offset            = req_bus.offset;
         s1_req_in.access_size       = req_bus.access_size;
         s1_req_in.write_data        = req_bus.write_data;
         s1_req_in.current_word      = req_bus.current_word;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_rsp_in   = out_rsp_ff;
      if (out_free) begin
         out_valid_in = s1_valid_ff;
         out_rsp_in   = fix_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff  <= s1_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.status        = out_rsp_ff.status;
   assign rsp_bus.read_data     = out_rsp_ff.read_data;
   assign rsp_bus.write_enable  = out_rsp_ff.write_enable;
   assign rsp_bus.write_address = out_rsp_ff.write_address;
   assign rsp_bus.write_word    = out_rsp_ff.write_word;

   // A write-back is only ever produced for a found access.
   a_we_implies_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.write_enable) |->
         (rsp_bus.status == pbcas_pkg::STATUS_OK))
      else $error("write-back issued with not-found status");

   // Write-back addresses are word aligned.
   a_we_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.write_enable) |->
         (rsp_bus.write_address[1:0] == 2'b00))
      else $error("unaligned write-back address");

   // An accepted request always lands in the input register.
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request lost");

   // With both registers full and the result stalled, no request is taken.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while pipeline full");

endmodule

>>> tb/sv/pcie_bridge_config_access_shim_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcie_bridge_config_access_shim_test
// Drives bridge configuration reads and writes into the access shim. Each
// request is also fed to a behavioral model of the read patching, narrow write
// merge and write-1-to-clear logic. Every result from the block is compared
// field by field with the oldest predicted one. The run goes through several
// settings of the enhanced-allocation registers, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module pcie_bridge_config_access_shim_test;

   typedef pbcas_pkg::req_type req_type;
   typedef pbcas_pkg::rsp_type rsp_type;

   localparam logic        OP_READ          = pbcas_pkg::OP_READ;
   localparam logic        OP_WRITE         = pbcas_pkg::OP_WRITE;
   localparam logic [2:0]  SIZE_BYTE        = pbcas_pkg::SIZE_BYTE;
   localparam logic [2:0]  SIZE_HALF        = pbcas_pkg::SIZE_HALF;
   localparam logic        STATUS_OK        = pbcas_pkg::STATUS_OK;
   localparam logic        STATUS_NOT_FOUND = pbcas_pkg::STATUS_NOT_FOUND;
   localparam logic [1:0]  REG_EA_BASE_LOW  = pbcas_pkg::REG_EA_BASE_LOW;
   localparam logic [1:0]  REG_EA_SIZE      = pbcas_pkg::REG_EA_SIZE;
   localparam logic [1:0]  REG_EA_BASE_HIGH = pbcas_pkg::REG_EA_BASE_HIGH;
   localparam int          CSR_ADDR_WIDTH   = pbcas_pkg::CSR_ADDR_WIDTH;
   localparam logic [11:0] LIMIT_OFFSET     = pbcas_pkg::LIMIT_OFFSET;

   localparam logic [2:0] SIZE_WORD   = 3'd4;
   localparam logic [2:0] SIZE_NONE   = 3'd0;
   localparam logic [2:0] SIZE_TRIPLE = 3'd3;
   localparam logic [2:0] SIZE_MAX    = 3'd7;
   localparam int         STALL_LIMIT = 2000;

   localparam logic [11:0] SPECIAL_OFFSETS [23] = '{
      12'h000, 12'h004, 12'h008, 12'h00c, 12'h018, 12'h01c, 12'h024, 12'h040,
      12'h044, 12'h05c, 12'h060, 12'h064, 12'h070, 12'h078, 12'h080, 12'h088,
      12'h090, 12'h0a0, 12'h104, 12'h110, 12'h130, 12'h180, 12'h7fc
   };

   class access_scoreboard;
      rsp_type     pending[$];
      logic [31:0] ea_base_low;
      logic [31:0] ea_size;
      logic [31:0] ea_base_high;
      int          errors;
      int          results_seen;

      function new();
         ea_base_low  = '0;
         ea_size      = '0;
         ea_base_high = '0;
         errors       = 0;
         results_seen = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            REG_EA_BASE_LOW:  ea_base_low  = value;
            REG_EA_SIZE:      ea_size      = value;
            REG_EA_BASE_HIGH: ea_base_high = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] patched_word(logic [11:0] aligned, logic [31:0] raw);
         logic [31:0] word;
         word = raw;
         case (aligned)
            12'h000: word = 32'hA02D177D;
            12'h004: word = 32'h00100006;
            12'h008: word = 32'h06040100;
            12'h00c: word = 32'h00010000;
            12'h018: word = 32'h00010100;
            12'h040: word = (raw & 32'hffff00ff) | 32'h00005000;
            12'h05c: word = ea_base_low;
            12'h060: word = ea_size;
            12'h064: word = ea_base_high;
            // A zero interrupt vector field reads back as vector one.
            12'h070: if (raw[29:25] == 5'd0) word[25] = 1'b1;
            default: ;
         endcase
         return word;
      endfunction

      function logic [31:0] w1c_mask(logic [11:0] aligned);
         case (aligned)
            12'h004, 12'h01c: return 32'hff000000;
            12'h044: return 32'hfffffe00;
            12'h078, 12'h080, 12'h088, 12'h090, 12'h0a0: return 32'hffff0000;
            12'h104, 12'h110, 12'h130, 12'h180: return 32'hffffffff;
            default: return 32'h0;
         endcase
      endfunction

      function logic [31:0] forced_ones(logic [11:0] aligned);
         case (aligned)
            12'h01c: return 32'h00000101;
            12'h024: return 32'h00010001;
            default: return 32'h0;
         endcase
      endfunction

      function rsp_type predict_access(req_type r);
         rsp_type     o;
         logic [11:0] aligned;
         int unsigned shift;
         logic [31:0] word;
         logic [31:0] lanes;
         logic [31:0] keep;
         o       = '0;
         aligned = {r.offset[11:2], 2'b00};
         shift   = 8 * r.offset[1:0];
         if (r.function_number != 8'd0 || r.offset >= LIMIT_OFFSET) begin
            o.status = STATUS_NOT_FOUND;
            if (r.op == OP_READ) o.read_data = '1;
            return o;
         end
         o.status = STATUS_OK;
         if (r.op == OP_READ) begin
            word = patched_word(aligned, r.current_word) >> shift;
            if (r.access_size == SIZE_BYTE) word &= 32'h000000ff;
            else if (r.access_size == SIZE_HALF) word &= 32'h0000ffff;
            o.read_data = word;
         end else begin
            word = r.write_data;
            if (r.access_size == SIZE_BYTE || r.access_size == SIZE_HALF) begin
               lanes = (r.access_size == SIZE_BYTE) ? 32'h000000ff : 32'h0000ffff;
               // Lanes shifted past bit 31 simply fall off the word.
               keep = ~(lanes << shift);
               word = ((r.write_data & lanes) << shift) | (r.current_word & keep);
               word &= ~(keep & w1c_mask(aligned));
            end
            word |= forced_ones(aligned);
            o.write_enable  = 1'b1;
            o.write_address = aligned[10:0];
            o.write_word    = word;
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending.push_back(predict_access(r));
      endfunction

      task report(string what);
         $display("MISMATCH: %s", what);
         errors++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got 0x%08h, expected 0x%08h",
                             results_seen, name, got, want));
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("result %0d arrived with no request outstanding",
                             results_seen));
         end else begin
            want = pending.pop_front();
            compare_field("status", 32'(got.status), 32'(want.status));
            compare_field("read_data", got.read_data, want.read_data);
            compare_field("write_enable", 32'(got.write_enable),
                          32'(want.write_enable));
            compare_field("write_address", 32'(got.write_address),
                          32'(want.write_address));
            compare_field("write_word", got.write_word, want.write_word);
         end
         results_seen++;
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   pbcas_req_if req_bus ();
   pbcas_rsp_if rsp_bus ();

   access_scoreboard sb;
   int               stall_pct;
   int               rsp_hold;
   int               quiet_cycles;

   pcie_bridge_config_access_shim DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Result side: random back-pressure in bursts.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_bus.ready = 1'b0;
         rsp_hold = $urandom_range(1, 15) - 1;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status        = rsp_bus.status;
         got.read_data     = rsp_bus.read_data;
         got.write_enable  = rsp_bus.write_enable;
         got.write_address = rsp_bus.write_address;
         got.write_word    = rsp_bus.write_word;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TIMEOUT: no request or result moved for %0d cycles", quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task send_request(req_type r);
      int gap;
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         gap = $urandom_range(1, 15);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.op              = r.op;
      req_bus.function_number = r.function_number;
      req_bus.offset          = r.offset;
      req_bus.access_size     = r.access_size;
      req_bus.write_data      = r.write_data;
      req_bus.current_word    = r.current_word;
      req_bus.valid           = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task write_reg(logic [1:0] index, logic [31:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_reg(index, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task set_ea_regs(logic [31:0] base_low, logic [31:0] size, logic [31:0] base_high);
      write_reg(REG_EA_BASE_LOW, base_low);
      write_reg(REG_EA_SIZE, size);
      write_reg(REG_EA_BASE_HIGH, base_high);
   endtask

   // Lets every outstanding request come back before the registers change.
   task drain();
      req_bus.valid = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   function req_type make_request(logic op, logic [7:0] fn, logic [11:0] offset,
                                  logic [2:0] size, logic [31:0] wdata,
                                  logic [31:0] cur);
      req_type r;
      r.op              = op;
      r.function_number = fn;
      r.offset          = offset;
      r.access_size     = size;
      r.write_data      = wdata;
      r.current_word    = cur;
      return r;
   endfunction

   function req_type random_request();
      req_type r;
      int      pick;
      r.op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
      pick = $urandom_range(0, 99);
      if (pick < 85) r.function_number = 8'd0;
      else r.function_number = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 60)
         r.offset = SPECIAL_OFFSETS[$urandom_range(0, 22)] | 12'($urandom_range(0, 3));
      else if (pick < 90)
         r.offset = 12'($urandom_range(0, 2047));
      else
         r.offset = 12'($urandom_range(0, 4095));
      pick = $urandom_range(0, 99);
      if (pick < 30) r.access_size = SIZE_BYTE;
      else if (pick < 60) r.access_size = SIZE_HALF;
      else if (pick < 85) r.access_size = SIZE_WORD;
      else r.access_size = 3'($urandom_range(0, 7));
      r.write_data   = $urandom;
      r.current_word = $urandom;
      // Often leave the interrupt vector field empty.
      if ($urandom_range(0, 3) == 0) r.current_word[29:25] = 5'd0;
      return r;
   endfunction

   task run_random(int count, bit calm);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 40;
            endcase
            if (calm) stall_pct = 0;
         end
         send_request(random_request());
      end
   endtask

   initial begin
      sb                      = new();
      stall_pct               = 0;
      rsp_hold                = 0;
      quiet_cycles            = 0;
      reset                   = 1'b1;
      psel                    = 1'b0;
      penable                 = 1'b0;
      pwrite                  = 1'b0;
      paddr                   = '0;
      pwdata                  = '0;
      req_bus.valid           = 1'b0;
      req_bus.op              = OP_READ;
      req_bus.function_number = '0;
      req_bus.offset          = '0;
      req_bus.access_size     = SIZE_WORD;
      req_bus.write_data      = '0;
      req_bus.current_word    = '0;
      rsp_bus.ready           = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      set_ea_regs(32'hffffffff, 32'h80000001, 32'h00000000);
      stall_pct = 20;
      // Identity and header words, with shifted and masked narrow reads.
      send_request(make_request(OP_READ, 8'd0, 12'h000, SIZE_WORD, 32'h0, 32'h12345678));
      send_request(make_request(OP_READ, 8'd0, 12'h006, SIZE_HALF, 32'h0, 32'hffffffff));
      send_request(make_request(OP_READ, 8'd0, 12'h00b, SIZE_BYTE, 32'h0, 32'h0));
      send_request(make_request(OP_READ, 8'd0, 12'h00c, SIZE_WORD, 32'h0, 32'h0));
      send_request(make_request(OP_READ, 8'd0, 12'h018, SIZE_WORD, 32'h0, 32'h0));
      send_request(make_request(OP_READ, 8'd0, 12'h040, SIZE_WORD, 32'h0, 32'hffffffff));
      send_request(make_request(OP_READ, 8'd0, 12'h05c, SIZE_WORD, 32'h0, 32'h0));
      send_request(make_request(OP_READ, 8'd0, 12'h061, SIZE_BYTE, 32'h0, 32'h0));
      send_request(make_request(OP_READ, 8'd0, 12'h064, SIZE_WORD, 32'h0, 32'hffffffff));
      send_request(make_request(OP_READ, 8'd0, 12'h070, SIZE_WORD, 32'h0, 32'hc1ffffff));
      send_request(make_request(OP_READ, 8'd0, 12'h070, SIZE_WORD, 32'h0, 32'h04000000));
      // Unusual read sizes return the shifted word unmasked; then a byte read at the top offset.
      send_request(make_request(OP_READ, 8'd0, 12'h103, SIZE_TRIPLE, 32'h0, 32'hdeadbeef));
      send_request(make_request(OP_READ, 8'd0, 12'h7ff, SIZE_BYTE, 32'h0, 32'hab000000));
      // Device not found: foreign function or offset past the limit.
      send_request(make_request(OP_READ, 8'd255, 12'h000, SIZE_WORD, 32'h0, 32'h0));
      send_request(make_request(OP_READ, 8'd0, 12'h800, SIZE_BYTE, 32'h0, 32'h0));
      send_request(make_request(OP_WRITE, 8'd0, 12'hfff, SIZE_WORD, 32'hffffffff,
                                32'hffffffff));
      send_request(make_request(OP_WRITE, 8'd1, 12'h004, SIZE_WORD, 32'h1, 32'h0));
      // Writes: full word, narrow merges with clear bits, forced ones.
      send_request(make_request(OP_WRITE, 8'd0, 12'h004, SIZE_WORD, 32'hffffffff,
                                32'hffffffff));
      send_request(make_request(OP_WRITE, 8'd0, 12'h007, SIZE_BYTE, 32'h000000a5,
                                32'hffffffff));
      send_request(make_request(OP_WRITE, 8'd0, 12'h01e, SIZE_HALF, 32'hffff0000,
                                32'hffffffff));
      // A halfword at the last byte lane runs off the word.
      send_request(make_request(OP_WRITE, 8'd0, 12'h047, SIZE_HALF, 32'h0000ffff,
                                32'hffffffff));
      send_request(make_request(OP_WRITE, 8'd0, 12'h024, SIZE_WORD, 32'h0, 32'h0));
      send_request(make_request(OP_WRITE, 8'd0, 12'h181, SIZE_BYTE, 32'h00000000,
                                32'hffffffff));
      send_request(make_request(OP_WRITE, 8'd0, 12'h07a, SIZE_NONE, 32'h5a5a5a5a,
                                32'hffffffff));
      send_request(make_request(OP_WRITE, 8'd0, 12'h7fc, SIZE_MAX, 32'h0, 32'hffffffff));
      drain();

      set_ea_regs($urandom, $urandom, $urandom);
      run_random(450, 1'b0);
      drain();

      set_ea_regs(32'h00000000, 32'hffffffff, 32'hffffffff);
      run_random(450, 1'b0);
      drain();

      set_ea_regs($urandom, $urandom, $urandom);
      stall_pct = 0;
      run_random(500, 1'b1);
      drain();

      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

>>> files.f
src/pbcas_pkg.sv
src/pbcas_if.sv
src/pbcas_csr.sv
src/pbcas_fixup.sv
src/pcie_bridge_config_access_shim.sv
tb/sv/pcie_bridge_config_access_shim_test.sv
